// ===== hw/rtl/mthw_pkg.sv =====
`timescale 1ns / 1ps

package mthw_pkg;

  localparam int NUM_TASKS_DEF    = 5;
  localparam int WARN_PERIOD_DEF  = 50;
  localparam logic [31:0] THRESH_RESET = 32'd2000;

  localparam int CNT_W    = 32;
  localparam int ID_W     = 3;
  localparam int ACTION_W = 2;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 40;

  localparam logic [ACTION_W-1:0] ACT_HEARTBEAT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd2;

  // check result rippling down the row of task cells
  typedef struct packed {
    logic             pass;   // every task so far passed
    logic             hit;    // a stuck task was found upstream
    logic [ID_W-1:0]  id;
    logic             warn;
    logic [CNT_W-1:0] stall;
  } chain_t;

endpackage

// ===== hw/rtl/multi_task_heartbeat_watchdog.sv =====
`timescale 1ns / 1ps
// a check tick request gives its result in the output register in the next cycle
// throughput: one request per cycle; the check ripples combinationally through the row of
// task cells, so the only stall comes from a full output register
// heartbeat and clear requests give no result
// reset (rst, synchronous): all counts, backups and stall counters clear, threshold 2000
module multi_task_heartbeat_watchdog #(
  parameter int NUM_TASKS   = mthw_pkg::NUM_TASKS_DEF,
  parameter int WARN_PERIOD = mthw_pkg::WARN_PERIOD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mthw_pkg::IN_W-1:0]  s_tdata,   // action[1:0], task_id[4:2]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mthw_pkg::OUT_W-1:0] m_tdata,   // feed[0], stuck_task[3:1], warn[4],
                                                // stall_ticks[36:5]
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [31:0]                cfg_data
);
  import mthw_pkg::*;

  localparam logic [ID_W-1:0] NONE_ID = ID_W'(NUM_TASKS);

  logic [31:0]         thresh;
  logic                accept;
  logic                tick_acc;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     task_id;
  chain_t              chain [NUM_TASKS+1];

  logic                feed_r;
  logic [ID_W-1:0]     stuck_r;
  logic                warn_r;
  logic [CNT_W-1:0]    stall_r;

  assign action    = s_tdata[ACTION_W-1:0];
  assign task_id   = s_tdata[ACTION_W+ID_W-1:ACTION_W];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign tick_acc  = accept && (action == ACT_TICK);
  assign cfg_ready = 1'b1;

  assign chain[0] = '{pass: 1'b1, hit: 1'b0, id: '0, warn: 1'b0, stall: '0};

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    logic hb;
    logic clr;
    assign hb  = accept && (action == ACT_HEARTBEAT) && (32'(task_id) == i);
    assign clr = accept && (action == ACT_CLEAR) && (32'(task_id) == i);
    mthw_cell #(
      .WARN_PERIOD (WARN_PERIOD),
      .CELL_ID     (ID_W'(i))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .hb        (hb),
      .clr       (clr),
      .tick      (tick_acc),
      .thresh    (thresh),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thresh <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tick_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      feed_r  <= chain[NUM_TASKS].pass;
      stuck_r <= chain[NUM_TASKS].pass ? NONE_ID : chain[NUM_TASKS].id;
      warn_r  <= chain[NUM_TASKS].warn;
      stall_r <= chain[NUM_TASKS].stall;
    end
  end

  assign m_tdata = {3'b000, stall_r, warn_r, stuck_r, feed_r};

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> m_tvalid)
    else $error("tick request left no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    accept && !tick_acc && !m_tvalid |=> !m_tvalid)
    else $error("result without a tick request");

  a_feed_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && feed_r |-> !warn_r && (stall_r == '0) && (stuck_r == NONE_ID))
    else $error("fed result carries stuck task data");

  a_chain_pass: assert property (@(posedge clk) disable iff (rst)
    chain[NUM_TASKS].pass |-> !chain[NUM_TASKS].hit)
    else $error("check both passed and found a stuck task");

endmodule

// ===== hw/rtl/mthw_cell.sv =====
`timescale 1ns / 1ps

module mthw_cell #(
  parameter int WARN_PERIOD = 50,
  parameter logic [2:0] CELL_ID = 3'd0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              hb,
  input  logic              clr,
  input  logic              tick,
  input  logic [31:0]       thresh,
  input  mthw_pkg::chain_t  chain_in,
  output mthw_pkg::chain_t  chain_out
);
  import mthw_pkg::*;

  localparam int MOD_W = (WARN_PERIOD > 1) ? $clog2(WARN_PERIOD) : 1;
  localparam logic [MOD_W-1:0] MOD_LAST = MOD_W'(WARN_PERIOD - 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] backup;
  logic [CNT_W-1:0] stall;
  logic [MOD_W-1:0] stall_mod;   // stall modulo the warn period

  logic             stuck;
  logic             take;
  logic             first;
  logic [CNT_W-1:0] stall_inc;
  logic [MOD_W-1:0] mod_inc;
  logic             warn;

  assign stuck     = (count != '0) && (count == backup);
  assign take      = chain_in.pass && !stuck;
  assign first     = chain_in.pass && stuck;
  assign stall_inc = stall + 1'b1;
  // a wrap of the stall counter restarts the period as well
  assign mod_inc   = ((stall == '1) || (stall_mod == MOD_LAST)) ? '0 : stall_mod + 1'b1;
  assign warn      = (stall_inc >= thresh) && (mod_inc == '0);

  always_comb begin
    chain_out      = chain_in;
    chain_out.pass = take;
    if (first) begin
      chain_out.hit   = 1'b1;
      chain_out.id    = CELL_ID;
      chain_out.warn  = warn;
      chain_out.stall = stall_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      backup    <= '0;
      stall     <= '0;
      stall_mod <= '0;
    end else begin
      if (hb) begin
        count <= count + 1'b1;
      end else if (clr) begin
        count <= '0;
      end
      if (tick) begin
        if (take) begin
          backup    <= count;
          stall     <= '0;
          stall_mod <= '0;
        end else begin
          stall     <= stall_inc;
          stall_mod <= mod_inc;
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mthw_pkg::*;

  localparam int TASKS = NUM_TASKS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_REQUESTS = 230;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic             drain;  // hold off until every tick result is back
    logic [4:0]       hold;
    logic [ID_W-1:0]  id;
    logic [ACTION_W-1:0] act;
  } request_t;

  typedef struct packed {
    logic             feed;
    logic [ID_W-1:0]  stuck;
    logic             warn;
    logic [CNT_W-1:0] stall;
  } verdict_t;

  typedef enum int {ALIVE, SUSPENDED, HUNG, SILENT} habit_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_data = '0;

  // supervisor state as the block should hold it
  logic [CNT_W-1:0]  beat_count  [TASKS];
  logic [CNT_W-1:0]  beat_backup [TASKS];
  logic [CNT_W-1:0]  stall_count [TASKS];
  logic [CNT_W-1:0]  warn_level;

  request_t outbound[$];
  verdict_t tick_results[$];

  int  failures = 0;
  int  cycles = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  int  counted = 0;
  bit  armed = 0;
  bit  tx_calm = 0;
  bit  rx_calm = 0;
  bit  next_drain = 0;

  multi_task_heartbeat_watchdog DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic apply_request(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id);
    verdict_t v;
    bit found;
    int i;
    if (act == ACT_HEARTBEAT || act == ACT_CLEAR) begin
      if (id < TASKS) begin
        if (act == ACT_HEARTBEAT) beat_count[id] = beat_count[id] + 1;
        else beat_count[id] = '0;
      end
    end else if (act == ACT_TICK) begin
      for (i = 0; i < TASKS; i++) stall_count[i] = stall_count[i] + 1;
      found = 0;
      v.feed = 1'b1;
      v.stuck = ID_W'(TASKS);
      v.warn = 1'b0;
      v.stall = '0;
      for (i = 0; i < TASKS && !found; i++) begin
        if (beat_count[i] != 0 && beat_backup[i] == beat_count[i]) begin
          // first stuck task ends the scan, later tasks keep their counters
          found = 1;
          v.feed = 1'b0;
          v.stuck = ID_W'(i);
          v.warn = (stall_count[i] >= warn_level) && (stall_count[i] % WARN_PERIOD_DEF == 0);
          v.stall = stall_count[i];
        end else begin
          beat_backup[i] = beat_count[i];
          stall_count[i] = '0;
        end
      end
      tick_results.push_back(v);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    request_t head;
    if (rst) begin
      s_tvalid <= 1'b0;
      armed = 0;
    end else begin
      if (s_tvalid && s_tready) apply_request(s_tdata[1:0], s_tdata[4:2]);
      if (!s_tvalid || s_tready) begin
        if (outbound.size() == 0) begin
          s_tvalid <= 1'b0;
        end else begin
          head = outbound[0];
          if (!armed) begin
            tx_wait = head.hold;
            armed = 1;
          end
          if (tx_wait > 0) begin
            tx_wait--;
            s_tvalid <= 1'b0;
          end else if (head.drain && tick_results.size() != 0) begin
            s_tvalid <= 1'b0;
          end else begin
            void'(outbound.pop_front());
            armed = 0;
            s_tvalid <= 1'b1;
            s_tdata <= {{(IN_W - ID_W - ACTION_W){1'b0}}, head.id, head.act};
          end
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (tick_results.size() == 0) begin
          $error("result with no tick pending: m_tdata %h", m_tdata);
          failures++;
        end else begin
          want = tick_results.pop_front();
          if (m_tdata[0] !== want.feed) begin
            $error("feed: expected %0d, got %0d", want.feed, m_tdata[0]);
            failures++;
          end
          if (m_tdata[3:1] !== want.stuck) begin
            $error("stuck_task: expected %0d, got %0d", want.stuck, m_tdata[3:1]);
            failures++;
          end
          if (m_tdata[4] !== want.warn) begin
            $error("warn: expected %0d, got %0d", want.warn, m_tdata[4]);
            failures++;
          end
          if (m_tdata[36:5] !== want.stall) begin
            $error("stall_ticks: expected %0d, got %0d", want.stall, m_tdata[36:5]);
            failures++;
          end
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 17);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_request(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] id,
                               input bit real_work);
    request_t r;
    r.act = act;
    r.id = id;
    r.hold = tx_calm ? 5'd0 : 5'($urandom_range(0, 17));
    r.drain = next_drain;
    next_drain = 0;
    outbound.push_back(r);
    if (real_work) counted++;
  endtask

  task automatic queue_noise();
    case ($urandom_range(0, 2))
      0: queue_request(ACT_UNUSED, ID_W'($urandom_range(0, 7)), 0);
      1: queue_request($urandom_range(0, 1) ? ACT_HEARTBEAT : ACT_CLEAR,
                       ID_W'($urandom_range(TASKS, 7)), 0);
      default: queue_request(ACTION_W'($urandom), ID_W'($urandom), 0);
    endcase
  endtask

  // one stretch of ticks with a fixed behavior per task
  task automatic queue_episode(input bit long_hang);
    habit_t habit [TASKS];
    int ticks;
    int victim;
    int t;
    int pick;
    tx_calm = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) == 0) next_drain = 1;
    victim = $urandom_range(0, TASKS - 1);
    ticks = long_hang ? $urandom_range(50, 110) : $urandom_range(1, 8);
    for (t = 0; t < TASKS; t++) begin
      if (long_hang) begin
        if (t < victim) habit[t] = ($urandom_range(0, 2) == 0) ? ALIVE : SUSPENDED;
        else if (t == victim) habit[t] = HUNG;
        else habit[t] = SILENT;
      end else begin
        pick = $urandom_range(0, 9);
        habit[t] = (pick < 5) ? ALIVE : (pick < 7) ? SUSPENDED : HUNG;
      end
    end
    for (t = 0; t < TASKS; t++) begin
      if (habit[t] == SUSPENDED) queue_request(ACT_CLEAR, ID_W'(t), 1);
      else if (habit[t] == HUNG) queue_request(ACT_HEARTBEAT, ID_W'(t), 1);
    end
    repeat (ticks) begin
      for (t = 0; t < TASKS; t++) begin
        // live tasks now and then miss a beat outside the long hangs
        if (habit[t] == ALIVE && (long_hang || $urandom_range(0, 9) != 0)) begin
          repeat ($urandom_range(1, 2)) queue_request(ACT_HEARTBEAT, ID_W'(t), 1);
        end
      end
      if ($urandom_range(0, 9) == 0) queue_noise();
      queue_request(ACT_TICK, '0, 1);
    end
  endtask

  task automatic wait_idle();
    while (outbound.size() != 0 || s_tvalid || tick_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    warn_level = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] levels [6];
    int p;
    int t;
    for (t = 0; t < TASKS; t++) begin
      beat_count[t] = '0;
      beat_backup[t] = '0;
      stall_count[t] = '0;
    end
    warn_level = THRESH_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests under the reset threshold
    tx_calm = 1;
    queue_request(ACT_TICK, '0, 1);
    for (t = 0; t < TASKS; t++) queue_request(ACT_HEARTBEAT, ID_W'(t), 1);
    queue_request(ACT_HEARTBEAT, 3'd5, 1);
    queue_request(ACT_HEARTBEAT, 3'd6, 1);
    queue_request(ACT_HEARTBEAT, 3'd7, 1);
    queue_request(ACT_TICK, '0, 1);
    queue_request(ACT_TICK, '0, 1);
    queue_request(ACT_CLEAR, 3'd7, 1);
    queue_request(ACT_UNUSED, 3'd7, 1);
    queue_request(ACT_UNUSED, 3'd0, 1);
    queue_request(ACT_CLEAR, 3'd0, 1);
    queue_request(ACT_TICK, '0, 1);
    queue_request(ACT_CLEAR, 3'd1, 1);
    queue_request(ACT_CLEAR, 3'd2, 1);
    queue_request(ACT_CLEAR, 3'd3, 1);
    queue_request(ACT_HEARTBEAT, 3'd4, 1);
    queue_request(ACT_TICK, '0, 1);
    queue_request(ACT_TICK, '0, 1);
    wait_idle();

    levels[0] = 32'd0;
    levels[1] = 32'd50;
    levels[2] = 32'hFFFF_FFFF;
    levels[3] = $urandom;
    levels[4] = $urandom_range(0, 300);
    levels[5] = 32'd100;
    for (p = 0; p < 6; p++) begin
      write_threshold(levels[p]);
      counted = 0;
      queue_episode(1);
      while (counted < PHASE_REQUESTS) queue_episode($urandom_range(0, 9) == 0);
      wait_idle();
    end

    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
